### sv/ctsc_pkg.sv
package ctsc_pkg;

	// control flags that travel down the pipeline beside the data
	typedef struct packed {
		logic valid;
		logic tanh;
		logic zero;
	} ctsc_ctl_t;

	// operation codes
	localparam logic [1:0] OP_TANH = 2'd0;
	localparam logic [1:0] OP_SINE = 2'd1;
	localparam logic [1:0] OP_COS  = 2'd2;

	// real constant to fixed point, rounded to nearest with ties away from zero
	function automatic longint enc_fix(input real v, input int f);
		return longint'(v * (2.0 ** f));
	endfunction

endpackage

### sv/ctsc_reduce.sv
module ctsc_reduce
	import ctsc_pkg::*;
#(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic signed [31:0]  operand,
	input  logic [1:0]          operation,
	output ctsc_ctl_t           ctl,
	output logic signed [W-1:0] x
);

	localparam logic signed [W-1:0] K_PI     = W'(enc_fix(3.141592653589793238, F));
	localparam logic signed [W-1:0] K_HALFPI = W'(enc_fix(1.570796326794896619, F));
	localparam logic signed [W-1:0] K_INV2PI = W'(enc_fix(0.159154943091895336, F));
	localparam logic signed [W-1:0] K_2PI    = W'(enc_fix(6.283185307179586477, F));
	localparam logic signed [W-1:0] K_SCALE  = W'(enc_fix(8544566.0 / 33554432.0, F));
	localparam logic signed [W-1:0] K_FIFTH  = W'(enc_fix(13421773.0 / 67108864.0, F));
	localparam logic signed [W-1:0] K_FIVE   = W'(enc_fix(5.0, F));
	localparam logic signed [W-1:0] K_MFIVE  = W'(enc_fix(-5.0, F));
	localparam logic [W-1:0]        FMASK    = ~((W'(1) << F) - W'(1));

	function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [2*W-1:0] p;
		p = (2*W)'(a) * (2*W)'(b);
		return W'(p >>> F);
	endfunction

	logic signed [W-1:0] xin;
	logic signed [W-1:0] sarg;
	logic signed [W-1:0] clamp;

	ctsc_ctl_t           ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic signed [W-1:0] v_s1, a_s1, t_s1;
	logic signed [W-1:0] v_s2, a_s2, t_s2;
	logic signed [W-1:0] v_s3, a_s3, t_s3;
	logic signed [W-1:0] x_s4;

	// argument widening, cosine offset and tanh clamp
	assign xin  = W'(operand);
	assign sarg = (operation == OP_COS) ? (K_HALFPI - xin) : xin;
	always_comb begin
		clamp = xin;
		if (xin < K_MFIVE) clamp = K_MFIVE;
		if (K_FIVE < xin) clamp = K_FIVE;
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.tanh  <= (operation == OP_TANH);
			ctl_s1.zero  <= !(operation == OP_TANH || operation == OP_SINE
				|| operation == OP_COS);
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	// reduction datapath, at most one multiply a stage on each path
	always_ff @(posedge clk) begin
		if (en) begin
			v_s1 <= sarg;
			a_s1 <= sarg + K_PI;
			t_s1 <= clamp;
			v_s2 <= v_s1;
			a_s2 <= fmul(a_s1, K_INV2PI) & FMASK;
			t_s2 <= fmul(K_FIFTH, t_s1);
			v_s3 <= v_s2;
			a_s3 <= fmul(a_s2, K_2PI);
			t_s3 <= t_s2;
			x_s4 <= ctl_s3.tanh ? t_s3 : fmul(v_s3 - a_s3, K_SCALE);
		end
	end

	assign ctl = ctl_s4;
	assign x   = x_s4;

endmodule

### sv/ctsc_series.sv
module ctsc_series
	import ctsc_pkg::*;
#(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  ctsc_ctl_t           ctl,
	input  logic signed [W-1:0] x,
	output logic                out_valid,
	output logic signed [31:0]  value
);

	localparam int NT = 9;
	localparam logic signed [W-1:0] K_TWO = W'(enc_fix(2.0, F));
	localparam logic signed [W-1:0] K_ONE = W'(enc_fix(1.0, F));

	localparam logic signed [W-1:0] CT [NT] = '{
		W'(enc_fix(1.2514045938932097, F)),
		W'(enc_fix(-0.3655987797163166, F)),
		W'(enc_fix(0.17253141478140663, F)),
		W'(enc_fix(-0.08943445792774211, F)),
		W'(enc_fix(0.047703017901250824, F)),
		W'(enc_fix(-0.025830290571688078, F)),
		W'(enc_fix(0.014338801903468182, F)),
		W'(enc_fix(-0.008541730970059077, F)),
		W'(enc_fix(0.006123068578578948, F))};

	localparam logic signed [W-1:0] CS [NT] = '{
		W'(enc_fix(-0.07570787578233389, F)),
		W'(enc_fix(-0.8532364056408055, F)),
		W'(enc_fix(0.2474789050491474, F)),
		W'(enc_fix(-0.02719844932262742, F)),
		W'(enc_fix(0.001675005812710184, F)),
		'0, '0, '0, '0};

	function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [2*W-1:0] p;
		p = (2*W)'(a) * (2*W)'(b);
		return W'(p >>> F);
	endfunction

	function automatic logic signed [2*W-1:0] cmul(input logic signed [W-1:0] c,
		input logic signed [W-1:0] p);
		return (2*W)'(c) * (2*W)'(p);
	endfunction

	ctsc_ctl_t           ctl_s5;
	logic signed [W-1:0] x_s5, y_s5;

	// chain registers, index 0 holds the first term stage
	ctsc_ctl_t             cctl_s [NT-1];
	logic signed [W-1:0]   cy_s   [NT-1];
	logic signed [W-1:0]   ca_s   [NT-1];
	logic signed [W-1:0]   cb_s   [NT-1];
	logic signed [2*W-1:0] cacc_s [NT-1];

	ctsc_ctl_t             ctl_o;
	logic signed [31:0]    value_o;
	logic signed [2*W-1:0] acc_fin;
	logic signed [W-1:0]   c_fin;

	// y = 4x^2 - 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s5 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s5 <= x;
			y_s5 <= W'(fmul(x, x) <<< 2) - K_TWO;
		end
	end

	// first term and accumulator seed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cctl_s[0] <= '0;
		end else if (en) begin
			cctl_s[0] <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cy_s[0]   <= y_s5;
			ca_s[0]   <= fmul(x_s5, y_s5 - K_ONE);
			cb_s[0]   <= x_s5;
			cacc_s[0] <= cmul(ctl_s5.tanh ? CT[0] : CS[0], x_s5);
		end
	end

	// recurrence p(k) = y*p(k-1) - p(k-2), accumulating the previous term
	for (genvar j = 1; j < NT - 1; j++) begin : g_chain
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cctl_s[j] <= '0;
			end else if (en) begin
				cctl_s[j] <= cctl_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cy_s[j]   <= cy_s[j-1];
				ca_s[j]   <= fmul(cy_s[j-1], ca_s[j-1]) - cb_s[j-1];
				cb_s[j]   <= ca_s[j-1];
				cacc_s[j] <= cacc_s[j-1]
					+ cmul(cctl_s[j-1].tanh ? CT[j] : CS[j], ca_s[j-1]);
			end
		end
	end

	// last term, final shift and output word
	assign c_fin   = cctl_s[NT-2].tanh ? CT[NT-1] : CS[NT-1];
	assign acc_fin = cacc_s[NT-2] + cmul(c_fin, ca_s[NT-2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= cctl_s[NT-2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_o <= cctl_s[NT-2].zero ? '0 : 32'(W'(acc_fin >>> F));
		end
	end

	assign out_valid = ctl_o.valid;
	assign value     = value_o;

endmodule

### sv/chebyshev_tanh_sine_cosine_unit.sv
// channel   signals                                   payload
// input     operand_valid / operand_ready             operand[31:0], operation[1:0]
// output    value_valid / value_ready                 value[31:0]
//
// fully pipelined: one word accepted per cycle while the output is not stalled;
// pipeline depth is set by the chain of dependent multiplies (reduction, y, nine terms).
// arst_n clears the valid bits of every stage; data registers are not reset.
// a stall on the output freezes the whole pipeline; operand_ready follows it.
module chebyshev_tanh_sine_cosine_unit
	import ctsc_pkg::*;
#(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               operand_valid,
	output logic               operand_ready,
	input  logic signed [31:0] operand,
	input  logic [1:0]         operation,
	output logic               value_valid,
	input  logic               value_ready,
	output logic signed [31:0] value
);

	logic                      en;
	ctsc_ctl_t                 ctl;
	logic signed [WORD_BITS-1:0] x;

	// advance whenever the output stage is empty or being taken
	assign en            = !value_valid || value_ready;
	assign operand_ready = en;

	ctsc_reduce #(.W(WORD_BITS), .F(FRAC_BITS)) u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (operand_valid),
		.operand   (operand),
		.operation (operation),
		.ctl       (ctl),
		.x         (x)
	);

	ctsc_series #(.W(WORD_BITS), .F(FRAC_BITS)) u_series (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl       (ctl),
		.x         (x),
		.out_valid (value_valid),
		.value     (value)
	);

endmodule

### bench/chebyshev_tanh_sine_cosine_unit_test.sv
`timescale 1ns / 100ps

module chebyshev_tanh_sine_cosine_unit_test;
	import ctsc_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int PER_PHASE = 250;

	logic               clk;
	logic               arst_n;
	logic               operand_valid;
	logic               operand_ready;
	logic signed [31:0] operand;
	logic [1:0]         operation;
	logic               value_valid;
	logic               value_ready;
	logic signed [31:0] value;

	chebyshev_tanh_sine_cosine_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.operand_valid(operand_valid),
		.operand_ready(operand_ready),
		.operand(operand),
		.operation(operation),
		.value_valid(value_valid),
		.value_ready(value_ready),
		.value(value)
	);

	// directed word with an optional hand-worked answer
	typedef struct {
		logic [31:0] arg;
		logic [1:0]  op;
		bit          known;
		logic [31:0] res;
	} vector_t;

	vector_t vectors[22];
	logic signed [31:0] pending_values[$];
	int errors = 0;
	int cycles = 0;
	int phase = 0;

	// series coefficients as exact ratios
	longint unsigned tanh_num[9] = '{64'd12514045938932097, 64'd3655987797163166,
		64'd17253141478140663, 64'd8943445792774211, 64'd47703017901250824,
		64'd25830290571688078, 64'd14338801903468182, 64'd8541730970059077,
		64'd6123068578578948};
	longint unsigned tanh_den[9] = '{64'd10000000000000000, 64'd10000000000000000,
		64'd100000000000000000, 64'd100000000000000000, 64'd1000000000000000000,
		64'd1000000000000000000, 64'd1000000000000000000, 64'd1000000000000000000,
		64'd1000000000000000000};
	bit tanh_neg[9] = '{0, 1, 0, 1, 0, 1, 0, 1, 0};
	longint unsigned sine_num[5] = '{64'd7570787578233389, 64'd8532364056408055,
		64'd2474789050491474, 64'd2719844932262742, 64'd1675005812710184};
	longint unsigned sine_den[5] = '{64'd100000000000000000, 64'd10000000000000000,
		64'd10000000000000000, 64'd100000000000000000, 64'd1000000000000000000};
	bit sine_neg[5] = '{1, 1, 0, 1, 0};

	// ratio to 16-bit fraction fixed point, ties away from zero
	function automatic logic signed [31:0] to_fix(longint unsigned n, longint unsigned d,
			bit neg);
		longint unsigned q, r;
		int i;
		q = n / d;
		r = n % d;
		for (i = 0; i < 16; i++) begin
			q = q << 1;
			r = r << 1;
			if (r >= d) begin
				q = q + 1;
				r = r - d;
			end
		end
		if (r * 2 >= d)
			q = q + 1;
		if (neg)
			q = -q;
		return q[31:0];
	endfunction

	// truncating fixed-point multiply
	function automatic logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return p[47:16];
	endfunction

	// odd chebyshev series, tanh set or sine set
	function automatic logic signed [31:0] cheb_series(logic signed [31:0] x, bit tanh_set);
		logic signed [31:0] p[9];
		logic signed [31:0] y, z, c;
		longint acc;
		int n, i;
		n = tanh_set ? 9 : 5;
		y = (fx_mul(x, x) <<< 2) - 32'sd131072;
		z = y - 32'sd65536;
		p[0] = x;
		p[1] = fx_mul(x, z);
		for (i = 2; i < n; i++)
			p[i] = fx_mul(y, p[i - 1]) - p[i - 2];
		acc = 0;
		for (i = 0; i < n; i++) begin
			c = tanh_set ? to_fix(tanh_num[i], tanh_den[i], tanh_neg[i])
				: to_fix(sine_num[i], sine_den[i], sine_neg[i]);
			acc = acc + longint'(c) * longint'(p[i]);
		end
		return acc[47:16];
	endfunction

	function automatic logic signed [31:0] sine_fix(logic signed [31:0] v);
		logic signed [31:0] a;
		a = v + to_fix(64'd3141592653589793238, 64'd1000000000000000000, 0);
		a = fx_mul(a, to_fix(64'd159154943091895336, 64'd1000000000000000000, 0));
		a = a & ~32'sh0000ffff;
		a = fx_mul(a, to_fix(64'd6283185307179586477, 64'd1000000000000000000, 0));
		a = v - a;
		a = fx_mul(a, to_fix(64'd8544566, 64'd33554432, 0));
		return cheb_series(a, 0);
	endfunction

	function automatic logic signed [31:0] predict_value(logic signed [31:0] arg, logic [1:0] op);
		logic signed [31:0] v;
		case (op)
			OP_TANH: begin
				v = arg;
				if (v < -32'sd327680)
					v = -32'sd327680;
				if (v > 32'sd327680)
					v = 32'sd327680;
				v = fx_mul(to_fix(64'd13421773, 64'd67108864, 0), v);
				return cheb_series(v, 1);
			end
			OP_SINE: return sine_fix(arg);
			OP_COS: begin
				return sine_fix(to_fix(64'd1570796326794896619, 64'd1000000000000000000, 0)
					- arg);
			end
			default: return 32'sd0;
		endcase
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch: %s got %h want %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// sender idle chance per cycle for the current phase
	function automatic bit sender_idles();
		if (phase == 1)
			return $urandom_range(99) < 60;
		if (phase == 3)
			return $urandom_range(99) < 10;
		return 0;
	endfunction

	// offer one word, called at a falling edge, returns at a falling edge
	task automatic offer(logic [31:0] arg, logic [1:0] op, bit known, logic [31:0] res);
		while (sender_idles()) begin
			operand_valid <= 1'b0;
			@(negedge clk);
		end
		operand_valid <= 1'b1;
		operand <= arg;
		operation <= op;
		do @(posedge clk); while (!operand_ready);
		pending_values.push_back(known ? res : predict_value(arg, op));
		@(negedge clk);
	endtask

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL chebyshev_tanh_sine_cosine_unit");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off in the pressure phase
	initial begin
		bit held;
		held = 0;
		value_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (phase == 4 && !held) begin
				held = 1;
				value_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				value_ready <= 1'b1;
			end else if (phase == 2)
				value_ready <= $urandom_range(99) >= 60;
			else if (phase == 3)
				value_ready <= $urandom_range(99) >= 10;
			else
				value_ready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && value_valid && value_ready) begin
			if (pending_values.size() == 0)
				report("unexpected word", value, 32'h0);
			else if (value !== pending_values[0]) begin
				report("value", value, pending_values[0]);
				void'(pending_values.pop_front());
			end else
				void'(pending_values.pop_front());
		end
	end

	// stimulus
	initial begin
		logic [31:0] arg;
		logic [1:0] op;
		int i, k;
		clk = 1'b0;
		arst_n = 1'b0;
		operand_valid = 1'b0;
		operand = '0;
		operation = OP_TANH;
		vectors = '{
			'{32'h00000000, OP_TANH, 1, 32'h0},
			'{32'h80000000, OP_TANH, 0, 32'h0},
			'{32'h7fffffff, OP_TANH, 0, 32'h0},
			'{32'hfffb0000, OP_TANH, 0, 32'h0},
			'{32'h00050000, OP_TANH, 0, 32'h0},
			'{32'h00050001, OP_TANH, 0, 32'h0},
			'{32'hfffaffff, OP_TANH, 0, 32'h0},
			'{32'h00010000, OP_TANH, 0, 32'h0},
			'{32'h00000000, OP_SINE, 0, 32'h0},
			'{32'h80000000, OP_SINE, 0, 32'h0},
			'{32'h7fffffff, OP_SINE, 0, 32'h0},
			'{32'h0003243f, OP_SINE, 0, 32'h0},
			'{32'hfffcdbc1, OP_SINE, 0, 32'h0},
			'{32'h00010000, OP_SINE, 0, 32'h0},
			'{32'h00000000, OP_COS, 0, 32'h0},
			'{32'h80000000, OP_COS, 0, 32'h0},
			'{32'h7fffffff, OP_COS, 0, 32'h0},
			'{32'h0001921f, OP_COS, 0, 32'h0},
			'{32'h00000000, OP_UNUSED, 1, 32'h0},
			'{32'h80000000, OP_UNUSED, 1, 32'h0},
			'{32'h7fffffff, OP_UNUSED, 1, 32'h0},
			'{32'hffffffff, OP_UNUSED, 1, 32'h0}
		};
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed words
		for (i = 0; i < 22; i++)
			offer(vectors[i].arg, vectors[i].op, vectors[i].known, vectors[i].res);

		// random words, one block per phase
		for (k = 0; k < 5; k++) begin
			phase = k;
			for (i = 0; i < PER_PHASE; i++) begin
				case ($urandom_range(2))
					0: arg = $urandom;
					1: arg = $urandom_range(32'h00100000) - 32'h00080000;
					default: arg = $urandom_range(32'h000c0000) - 32'h00060000;
				endcase
				op = ($urandom_range(19) == 0) ? OP_UNUSED : 2'($urandom_range(2));
				offer(arg, op, 0, 32'h0);
			end
		end
		operand_valid <= 1'b0;
		phase = 0;

		// drain
		while (pending_values.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_values.size() == 0)
			$display("PASS chebyshev_tanh_sine_cosine_unit");
		else
			$display("FAIL chebyshev_tanh_sine_cosine_unit");
		$finish;
	end

endmodule

### sim.f
sv/ctsc_pkg.sv
sv/ctsc_reduce.sv
sv/ctsc_series.sv
sv/chebyshev_tanh_sine_cosine_unit.sv
bench/chebyshev_tanh_sine_cosine_unit_test.sv
